/* rtl/core/tpc_pkg.sv */
// Shared types and codes for the trie prefix counter.
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

  // Request type of a letter beat.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  localparam int unsigned OUT_COUNT_BITS = 16;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] prefix_count;
    logic [1:0]                status;
  } tpc_res_t;

endpackage

`default_nettype wire

/* rtl/core/tpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/tpc_ctrl.sv */
// Letter walk sequencer: child table and pass count read-modify-write.
`timescale 1ns / 1ps
`default_nettype none

module tpc_ctrl #(
  parameter int unsigned NODE_POOL  = 4096,
  parameter int unsigned ALPHABET   = 26,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned NB = $clog2(NODE_POOL),
  localparam int unsigned AW = $clog2(NODE_POOL * ALPHABET)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic                  in_req_type,
  input  wire logic [4:0]            in_letter,
  input  wire logic                  in_last_letter,
  output      logic                  child_we,
  output      logic [AW-1:0]         child_waddr,
  output      logic [NB-1:0]         child_wdata,
  output      logic [AW-1:0]         child_raddr,
  input  wire logic [NB-1:0]         child_rdata,
  output      logic                  pass_we,
  output      logic [NB-1:0]         pass_waddr,
  output      logic [COUNT_BITS-1:0] pass_wdata,
  output      logic [NB-1:0]         pass_raddr,
  input  wire logic [COUNT_BITS-1:0] pass_rdata,
  output      logic                  res_valid,
  output      tpc_pkg::tpc_res_t     res,
  input  wire logic                  res_ready
);

  import tpc_pkg::*;

  localparam int unsigned CDEPTH = NODE_POOL * ALPHABET;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHILD,
    S_CNT,
    S_RESULT
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [NB-1:0]   cursor_r, cursor_nxt;
  logic            miss_r, miss_nxt;
  logic            full_r, full_nxt;
  logic [NB:0]     next_free_r, next_free_nxt;
  logic            req_r, req_nxt;
  logic            last_r, last_nxt;
  logic [AW-1:0]   slot_r, slot_nxt;
  tpc_res_t        res_r, res_nxt;

  logic [AW-1:0]         slot_calc;
  logic                  oob;
  logic                  stop_full;
  logic                  stop_miss;
  logic                  pool_empty;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [COUNT_BITS-1:0] cnt_val;
  logic [31:0]           cnt_wide;

  // Slot of the incoming letter in the flattened child table.
  assign slot_calc = AW'(cursor_r) * AW'(ALPHABET) + AW'(in_letter);
  assign oob       = 32'(in_letter) >= ALPHABET;
  assign stop_full = full_r | (~miss_r & oob & (in_req_type == REQ_INSERT));
  assign stop_miss = miss_r | (~full_r & oob & (in_req_type == REQ_QUERY));
  assign pool_empty = next_free_r >= (NB + 1)'(NODE_POOL);

  // Saturating increment of the pass count just read.
  assign cnt_new = (pass_rdata == {COUNT_BITS{1'b1}}) ? pass_rdata
                                                      : pass_rdata + 1'b1;
  assign cnt_val  = (req_r == REQ_INSERT) ? cnt_new : pass_rdata;
  assign cnt_wide = 32'(cnt_val);

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cursor_nxt    = cursor_r;
    miss_nxt      = miss_r;
    full_nxt      = full_r;
    next_free_nxt = next_free_r;
    req_nxt       = req_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    res_nxt       = res_r;
    child_we      = 1'b0;
    child_waddr   = slot_r;
    child_wdata   = NB'(next_free_r);
    child_raddr   = slot_calc;
    pass_we       = 1'b0;
    pass_waddr    = NB'(next_free_r);
    pass_wdata    = COUNT_BITS'(1);
    pass_raddr    = child_rdata;

    case (state_r)
      S_CLEAR: begin
        child_we     = 1'b1;
        child_waddr  = clr_addr_r;
        child_wdata  = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(CDEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_req_type;
          last_nxt = in_last_letter;
          slot_nxt = slot_calc;
          if (stop_full || stop_miss) begin
            // The word's walk has stopped; only its last letter matters.
            if (in_last_letter) begin
              res_nxt.prefix_count = '0;
              res_nxt.status       = stop_full ? STAT_FULL : STAT_ABSENT;
              cursor_nxt = '0;
              miss_nxt   = 1'b0;
              full_nxt   = 1'b0;
              state_nxt  = S_RESULT;
            end else begin
              miss_nxt = stop_miss;
              full_nxt = stop_full;
            end
          end else begin
            state_nxt = S_CHILD;
          end
        end
      end

      S_CHILD: begin
        if (req_r == REQ_QUERY) begin
          if (child_rdata == '0) begin
            if (last_r) begin
              res_nxt.prefix_count = '0;
              res_nxt.status       = STAT_ABSENT;
              cursor_nxt = '0;
              state_nxt  = S_RESULT;
            end else begin
              miss_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            cursor_nxt = child_rdata;
            state_nxt  = last_r ? S_CNT : S_IDLE;
          end
        end else if (child_rdata == '0) begin
          if (pool_empty) begin
            if (last_r) begin
              res_nxt.prefix_count = '0;
              res_nxt.status       = STAT_FULL;
              cursor_nxt = '0;
              state_nxt  = S_RESULT;
            end else begin
              full_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            // A fresh node starts with a pass count of one.
            child_we      = 1'b1;
            pass_we       = 1'b1;
            next_free_nxt = next_free_r + 1'b1;
            if (last_r) begin
              res_nxt.prefix_count = OUT_COUNT_BITS'(1);
              res_nxt.status       = STAT_OK;
              cursor_nxt = '0;
              state_nxt  = S_RESULT;
            end else begin
              cursor_nxt = NB'(next_free_r);
              state_nxt  = S_IDLE;
            end
          end
        end else begin
          cursor_nxt = child_rdata;
          state_nxt  = S_CNT;
        end
      end

      S_CNT: begin
        if (req_r == REQ_INSERT) begin
          pass_we    = 1'b1;
          pass_waddr = cursor_r;
          pass_wdata = cnt_new;
        end
        if (last_r) begin
          res_nxt.prefix_count = cnt_wide[OUT_COUNT_BITS-1:0];
          res_nxt.status       = STAT_OK;
          cursor_nxt = '0;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cursor_r    <= '0;
      miss_r      <= 1'b0;
      full_r      <= 1'b0;
      next_free_r <= (NB + 1)'(1);
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cursor_r    <= cursor_nxt;
      miss_r      <= miss_nxt;
      full_r      <= full_nxt;
      next_free_r <= next_free_nxt;
    end
    req_r  <= req_nxt;
    last_r <= last_nxt;
    slot_r <= slot_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/tpc_outq.sv */
// Output register stage for result beats.
`timescale 1ns / 1ps
`default_nettype none

module tpc_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire tpc_pkg::tpc_res_t res,
  output      logic              res_ready,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [15:0]       out_prefix_count,
  output      logic [1:0]        out_status
);

  import tpc_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  tpc_res_t out_res_r, out_res_nxt;

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_prefix_count = out_res_r.prefix_count;
  assign out_status       = out_res_r.status;

endmodule

`default_nettype wire

/* rtl/core/trie_prefix_counter.sv */
// Top level of the trie prefix counter.
`timescale 1ns / 1ps
`default_nettype none

// Prefix tree over an ALPHABET-letter alphabet with a saturating pass count
// per node. Words arrive one letter per input beat; one result beat comes out
// at each word's last letter. After reset the child table is swept to zero,
// one entry a cycle, over its NODE_POOL*ALPHABET entries (106496 with the
// defaults); in_stall stays high meanwhile. Afterwards each letter waits for
// the synchronous child-table read, then for a read back of the pass count
// when it needs one (an insert through an existing node, or the last letter
// of a query); once the word's walk has stopped a letter skips both. A last
// letter then passes through a result state to hand the result to the output
// register, which lets a new word start while a result waits to be taken.
module trie_prefix_counter #(
  parameter int unsigned NODE_POOL  = 4096,
  parameter int unsigned ALPHABET   = 26,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_req_type,
  input  wire logic [4:0]  in_letter,
  input  wire logic        in_last_letter,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [15:0] out_prefix_count,
  output      logic [1:0]  out_status
);

  import tpc_pkg::*;

  localparam int unsigned NB = $clog2(NODE_POOL);
  localparam int unsigned AW = $clog2(NODE_POOL * ALPHABET);

  logic                  child_we;
  logic [AW-1:0]         child_waddr;
  logic [NB-1:0]         child_wdata;
  logic [AW-1:0]         child_raddr;
  logic [NB-1:0]         child_rdata;
  logic                  pass_we;
  logic [NB-1:0]         pass_waddr;
  logic [COUNT_BITS-1:0] pass_wdata;
  logic [NB-1:0]         pass_raddr;
  logic [COUNT_BITS-1:0] pass_rdata;
  logic                  res_valid;
  logic                  res_ready;
  tpc_res_t              res;

  tpc_ram #(
    .WIDTH (NB),
    .DEPTH (NODE_POOL * ALPHABET)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  tpc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NODE_POOL)
  ) u_pass_ram (
    .clk   (clk),
    .we    (pass_we),
    .waddr (pass_waddr),
    .wdata (pass_wdata),
    .raddr (pass_raddr),
    .rdata (pass_rdata)
  );

  tpc_ctrl #(
    .NODE_POOL  (NODE_POOL),
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_letter      (in_letter),
    .in_last_letter (in_last_letter),
    .child_we       (child_we),
    .child_waddr    (child_waddr),
    .child_wdata    (child_wdata),
    .child_raddr    (child_raddr),
    .child_rdata    (child_rdata),
    .pass_we        (pass_we),
    .pass_waddr     (pass_waddr),
    .pass_wdata     (pass_wdata),
    .pass_raddr     (pass_raddr),
    .pass_rdata     (pass_rdata),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  tpc_outq u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .res_ready        (res_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prefix_count (out_prefix_count),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

/* rtl/core/tpc_checker.sv */
// Port-level checks for the trie prefix counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tpc_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_prefix_count,
  input wire logic [1:0]  out_status
);

  import tpc_pkg::*;

  // The child table sweep starts straight after reset, so no letter is taken.
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("letter beat accepted straight after reset");

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_prefix_count) && $stable(out_status))
    else $error("result payload changed while stalled");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_ABSENT ||
                   out_status == STAT_FULL))
    else $error("undefined status code");

  // A failed walk reports a zero count; a successful one a non-zero count.
  a_count_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == STAT_OK) == (out_prefix_count != 16'd0)))
    else $error("count does not agree with status");

endmodule

bind trie_prefix_counter tpc_props u_tpc_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_prefix_count (out_prefix_count),
  .out_status       (out_status)
);

`default_nettype wire
